// File: hw/rtl/i2cts_pkg.sv
// ----------------------------------------------------------------------------
// i2cts_pkg
// Shared types and codes for the I2C master transfer sequencer: item layouts,
// item modes, event flag positions, status and flag-clear codes.
// ----------------------------------------------------------------------------
package i2cts_pkg;

	// Default sizing
	localparam int DEF_MAX_SEGMENTS  = 8;
	localparam int DEF_MAX_SEG_BYTES = 256;

	// Item modes
	localparam logic [1:0] MODE_DESC  = 2'd0;
	localparam logic [1:0] MODE_DATA  = 2'd1;
	localparam logic [1:0] MODE_START = 2'd2;
	localparam logic [1:0] MODE_EVENT = 2'd3;

	// Event flag bit positions
	localparam int EV_SB   = 0;
	localparam int EV_ADDR = 1;
	localparam int EV_BTF  = 2;
	localparam int EV_RXNE = 3;
	localparam int EV_TXE  = 4;
	localparam int EV_AF   = 5;
	localparam int EV_ERR  = 6;

	localparam logic [6:0] EV_TXE_ONLY = 7'(1 << EV_TXE);

	// Transfer status codes
	localparam logic [1:0] ST_BUSY   = 2'd0;
	localparam logic [1:0] ST_OK     = 2'd1;
	localparam logic [1:0] ST_NODEV  = 2'd2;
	localparam logic [1:0] ST_BUSERR = 2'd3;

	// Flag clear codes
	localparam logic [1:0] CLR_NONE = 2'd0;
	localparam logic [1:0] CLR_AF   = 2'd1;
	localparam logic [1:0] CLR_ALL  = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] seg_index;
		logic [7:0] byte_index;
		logic [6:0] slave_addr;
		logic       read_dir;
		logic [8:0] seg_length;
		logic [7:0] data_byte;
		logic [3:0] seg_count;
		logic [6:0] event_flags;
		logic       transmitter;
	} cmd_item_t;

	typedef struct packed {
		logic       handled;
		logic       dr_write;
		logic [7:0] dr_value;
		logic       start_bit;
		logic       ack_bit;
		logic [1:0] flag_clear;
		logic       rx_valid;
		logic [2:0] rx_segment;
		logic [7:0] rx_position;
		logic [7:0] rx_value;
		logic [1:0] xfer_status;
	} rsp_item_t;

endpackage

// File: hw/rtl/i2cts_ram.sv
// ----------------------------------------------------------------------------
// i2cts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2cts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/i2cts_prefetch_mem.sv
// ----------------------------------------------------------------------------
// i2cts_prefetch_mem
// RAM that reads the next cycle's address every cycle, with a bypass for a
// write landing on that same address, so the word at the current pointer is
// ready at the start of each cycle.
// ----------------------------------------------------------------------------
module i2cts_prefetch_mem #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_next,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] ram_rdata;
	logic             byp_hit_q;
	logic [WIDTH-1:0] byp_data_q;

	i2cts_ram #(
		.WIDTH (WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr_next),
		.rdata (ram_rdata)
	);

	// Catch a write to the word being fetched in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_hit_q <= 1'b0;
		end else begin
			byp_hit_q <= we && (waddr == raddr_next);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= wdata;
	end

	assign rdata = byp_hit_q ? byp_data_q : ram_rdata;

endmodule

// File: hw/rtl/i2c_master_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Sequences a multi-segment I2C master transfer one controller event at a
// time: stores segment descriptors and transmit bytes, and for each event
// item produces the data-register write, START/ACK bits, flag-clear code, any
// received byte and the transfer status.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                    | Direction | Item
//  --------+----------------------------+-----------+---------------------------
//  cmd     | cmd_valid, cmd_ready, cmd  | in        | load, start or event item
//  rsp     | rsp_valid, rsp_ready, rsp  | out       | one result per cmd item
//
//  An item is registered on acceptance, processed once the output register is
//  free and its result lands in the output register; one item per cycle is
//  sustained while rsp is not stalled. The descriptor table and byte store are
//  RAMs whose read port always fetches the word at the next segment/byte
//  pointer, so each event finds its operand ready. Reset clears pointers,
//  counters, status and control bits; the stores hold nothing until loaded.
//  A stalled rsp holds the result and stalls the item behind it; cmd is still
//  taken while the input register is free.
//
module i2c_master_transfer_sequencer
	import i2cts_pkg::*;
#(
	parameter int MAX_SEGMENTS  = DEF_MAX_SEGMENTS,
	parameter int MAX_SEG_BYTES = DEF_MAX_SEG_BYTES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_item_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	localparam int SEG_W      = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int LEFT_W     = $clog2(MAX_SEGMENTS + 1);
	localparam int POS_W      = $clog2(MAX_SEG_BYTES + 1);
	localparam int STORE_SIZE = MAX_SEGMENTS * MAX_SEG_BYTES;
	localparam int STORE_AW   = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
	localparam int DESC_W     = 7 + 1 + POS_W;

	// Flat store address of a segment and byte position
	function automatic logic [STORE_AW-1:0] store_addr(
		input logic [SEG_W-1:0] seg,
		input logic [POS_W-1:0] pos
	);
		logic [STORE_AW:0] full;
		full = (STORE_AW + 1)'(seg) * (STORE_AW + 1)'(MAX_SEG_BYTES)
			+ (STORE_AW + 1)'(pos);
		return full[STORE_AW-1:0];
	endfunction

	// Input register
	logic      s1_valid_q;
	cmd_item_t item_s1;

	// Output register
	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	// Sequencer state
	logic [SEG_W-1:0]  cs_q, cs_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [LEFT_W-1:0] left_q, left_d;
	logic [1:0]        status_q, status_d;
	logic              start_q, start_d;
	logic              ack_q, ack_d;

	// Memory ports
	logic                desc_we;
	logic [SEG_W-1:0]    desc_waddr;
	logic [DESC_W-1:0]   desc_wdata;
	logic [DESC_W-1:0]   desc_cur;
	logic                store_we;
	logic [STORE_AW-1:0] store_waddr;
	logic [7:0]          store_rd;

	// Current descriptor fields
	logic [6:0]       cur_addr;
	logic             cur_read;
	logic [POS_W-1:0] cur_len;

	logic      out_free;
	logic      s1_fire;
	rsp_item_t res;

	logic             seg_ok;
	logic             bidx_ok;
	logic [SEG_W-1:0] seg_ext;
	logic [POS_W-1:0] len_sat;
	logic [3:0]       cnt_sat;
	logic [POS_W-1:0] pos_rx;
	logic             do_end;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign s1_fire   = s1_valid_q && out_free;
	assign cmd_ready = !s1_valid_q || out_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign cur_len  = desc_cur[POS_W-1:0];
	assign cur_read = desc_cur[POS_W];
	assign cur_addr = desc_cur[POS_W+7:POS_W+1];

	// Operand decode of the registered item
	assign seg_ok  = 32'(item_s1.seg_index) < MAX_SEGMENTS;
	assign bidx_ok = 32'(item_s1.byte_index) < MAX_SEG_BYTES;
	assign seg_ext = SEG_W'(item_s1.seg_index);
	assign len_sat = (32'(item_s1.seg_length) > MAX_SEG_BYTES)
		? POS_W'(MAX_SEG_BYTES) : POS_W'(item_s1.seg_length);
	assign pos_rx  = (32'(pos_q) < MAX_SEG_BYTES) ? pos_q + 1'b1 : pos_q;

	always_comb begin
		if (item_s1.seg_count == 4'd0) begin
			cnt_sat = 4'd1;
		end else if (32'(item_s1.seg_count) > MAX_SEGMENTS) begin
			cnt_sat = 4'(MAX_SEGMENTS);
		end else begin
			cnt_sat = item_s1.seg_count;
		end
	end

	assign desc_waddr = seg_ext;
	assign desc_wdata = {item_s1.slave_addr, item_s1.read_dir, len_sat};

	// Per-item work: one pass over the registered item and the state
	always_comb begin
		cs_d        = cs_q;
		pos_d       = pos_q;
		left_d      = left_q;
		status_d    = status_q;
		start_d     = start_q;
		ack_d       = ack_q;
		desc_we     = 1'b0;
		store_we    = 1'b0;
		store_waddr = store_addr(cs_q, pos_q);
		do_end      = 1'b0;
		res         = '0;
		res.handled = 1'b1;

		if (s1_fire) begin
			case (item_s1.mode)
				MODE_DESC: begin
					desc_we = seg_ok;
				end
				MODE_DATA: begin
					store_we    = seg_ok && bidx_ok;
					store_waddr = store_addr(seg_ext, POS_W'(item_s1.byte_index));
				end
				MODE_START: begin
					left_d   = LEFT_W'(cnt_sat);
					cs_d     = '0;
					pos_d    = '0;
					status_d = ST_BUSY;
					start_d  = 1'b1;
				end
				MODE_EVENT: begin
					if (item_s1.event_flags == '0) begin
						res.handled = 1'b0;
					end else if (item_s1.event_flags[EV_SB]) begin
						// Address phase: send address with direction bit
						start_d      = 1'b0;
						res.dr_write = 1'b1;
						res.dr_value = {cur_addr, cur_read};
					end else if (item_s1.event_flags[EV_AF]) begin
						res.flag_clear = CLR_AF;
						status_d       = ST_NODEV;
					end else if (|item_s1.event_flags[EV_TXE:EV_ADDR]) begin
						// TX-empty alone needs no action
						if (item_s1.event_flags != EV_TXE_ONLY) begin
							ack_d = (({1'b0, pos_q} + 1'b1) != {1'b0, cur_len});
							if (item_s1.transmitter) begin
								if (pos_q < cur_len) begin
									res.dr_write = 1'b1;
									res.dr_value = store_rd;
									pos_d        = pos_q + 1'b1;
								end else begin
									do_end = 1'b1;
								end
							end else if (item_s1.event_flags[EV_RXNE]) begin
								if (32'(pos_q) < MAX_SEG_BYTES) begin
									store_we        = 1'b1;
									res.rx_valid    = 1'b1;
									res.rx_segment  = 3'(cs_q);
									res.rx_position = 8'(pos_q);
									res.rx_value    = item_s1.data_byte;
								end
								pos_d  = pos_rx;
								do_end = (pos_rx >= cur_len);
							end
						end
					end else begin
						res.flag_clear = CLR_ALL;
						status_d       = ST_BUSERR;
					end
				end
				default: begin
				end
			endcase
		end

		// Segment end: finish the transfer or restart on the next segment
		if (do_end) begin
			if (left_q <= LEFT_W'(1)) begin
				left_d   = '0;
				status_d = ST_OK;
			end else begin
				left_d  = left_q - 1'b1;
				cs_d    = (32'(cs_q) + 1 < MAX_SEGMENTS) ? cs_q + 1'b1 : '0;
				pos_d   = '0;
				start_d = 1'b1;
			end
		end

		res.start_bit   = start_d;
		res.ack_bit     = ack_d;
		res.xfer_status = status_d;
	end

	// Descriptor table, fetched at the next segment pointer
	i2cts_prefetch_mem #(
		.WIDTH (DESC_W),
		.DEPTH (MAX_SEGMENTS)
	) u_desc (
		.clk        (clk),
		.arst_n     (arst_n),
		.we         (desc_we),
		.waddr      (desc_waddr),
		.wdata      (desc_wdata),
		.raddr_next (cs_d),
		.rdata      (desc_cur)
	);

	// Byte store, fetched at the next segment/byte pointer
	i2cts_prefetch_mem #(
		.WIDTH (8),
		.DEPTH (STORE_SIZE)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.we         (store_we),
		.waddr      (store_waddr),
		.wdata      (item_s1.data_byte),
		.raddr_next (store_addr(cs_d, pos_d)),
		.rdata      (store_rd)
	);

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			cs_q        <= '0;
			pos_q       <= '0;
			left_q      <= '0;
			status_q    <= ST_BUSY;
			start_q     <= 1'b0;
			ack_q       <= 1'b0;
		end else begin
			if (cmd_ready) begin
				s1_valid_q <= cmd_valid;
			end
			if (s1_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			cs_q     <= cs_d;
			pos_q    <= pos_d;
			left_q   <= left_d;
			status_q <= status_d;
			start_q  <= start_d;
			ack_q    <= ack_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_s1 <= cmd;
		end
		if (s1_fire) begin
			rsp_q <= res;
		end
	end

endmodule
